FILE: sv/pts_pkg.sv
// Shared types, constants and codes for the periodic task tick scheduler.
`default_nettype none
package pts_pkg;

  localparam int TASKS       = 8;
  localparam int COUNT_WIDTH = 16;
  localparam int TIDX_W      = 3;
  localparam int MAX_OUT     = 8;
  localparam int NOUT_W      = 3;
  localparam int MASK_W      = 8;
  localparam int FAST_TICKS  = 101;
  localparam int SLOW_TICKS  = 301;
  localparam int SELECT_BIT  = 0;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_DISPATCH = 3'd1;
  localparam logic [2:0] OP_LOAD     = 3'd2;
  localparam logic [2:0] OP_INTERVAL = 3'd3;
  localparam logic [2:0] OP_SUSPEND  = 3'd4;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  function automatic logic [COUNT_WIDTH-1:0] sat_count(input logic [31:0] v);
    logic [COUNT_WIDTH-1:0] r;
    if (v > 32'(COUNT_MAX)) r = COUNT_MAX;
    else r = v[COUNT_WIDTH-1:0];
    return r;
  endfunction

  localparam logic [COUNT_WIDTH-1:0] FAST_RELOAD = sat_count(32'(FAST_TICKS));
  localparam logic [COUNT_WIDTH-1:0] SLOW_RELOAD = sat_count(32'(SLOW_TICKS));

  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  task_index;
    logic [15:0] interval_value;
    logic        suspend_bit;
  } pts_in_t;

  typedef struct packed {
    logic       valid_res;
    logic [2:0] task_index_out;
    logic       last;
    logic [7:0] ready_mask;
  } pts_out_t;

  // Classified command as held in the queue
  typedef struct packed {
    logic [2:0]             op;
    logic [TIDX_W-1:0]      idx;
    logic [COUNT_WIDTH-1:0] value;
    logic                   susp;
  } pts_cmd_t;

endpackage
`default_nettype wire

FILE: sv/pts_front.sv
// Front end: takes transactions, drops no-op ones and prepares slot write values.
`default_nettype none
module pts_front
  import pts_pkg::*;
(
  input  wire logic     start,
  input  wire pts_in_t  in_data,
  input  wire logic     q_full,
  output logic          busy,
  output logic          q_push,
  output pts_cmd_t      q_cmd
);

  logic        accept;
  logic        known_op;
  logic        slot_ok;
  logic        slot_op;
  logic [31:0] value32;

  assign busy   = q_full;
  assign accept = start && !q_full;

  always_comb begin
    value32  = 32'(in_data.interval_value);
    slot_ok  = 32'(in_data.task_index) < 32'(TASKS);
    slot_op  = (in_data.opcode == OP_LOAD) || (in_data.opcode == OP_INTERVAL) ||
               (in_data.opcode == OP_SUSPEND);
    known_op = (in_data.opcode == OP_TICK) || (in_data.opcode == OP_DISPATCH) ||
               (slot_op && slot_ok);

    q_cmd.op   = in_data.opcode;
    q_cmd.idx  = TIDX_W'(in_data.task_index);
    q_cmd.susp = in_data.suspend_bit;
    if (in_data.opcode == OP_INTERVAL) begin
      q_cmd.value = in_data.interval_value[SELECT_BIT] ? FAST_RELOAD : SLOW_RELOAD;
    end else begin
      q_cmd.value = value32[COUNT_WIDTH-1:0];
    end
  end

  assign q_push = accept && known_op;

endmodule
`default_nettype wire

FILE: sv/pts_queue.sv
// Short command queue between the front end and the execution unit.
`default_nettype none
module pts_queue
  import pts_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire pts_cmd_t push_cmd,
  input  wire logic     pop,
  output logic          full,
  output logic          empty,
  output pts_cmd_t      head
);

  pts_cmd_t            mem [QDEPTH];
  logic [QPTR_W-1:0]   wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]   rptr_r, rptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full    = cnt_r == QCNT_W'(QDEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr_r] <= push_cmd;
  end

endmodule
`default_nettype wire

FILE: sv/pts_back.sv
// Execution unit: slot table, tick lanes and the one-per-cycle dispatch scan.
`default_nettype none
module pts_back
  import pts_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_empty,
  input  wire pts_cmd_t q_head,
  output logic          q_pop,
  output logic          out_strobe,
  output pts_out_t      out_res
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DISP = 1'b1;

  logic                   state_r, state_nxt;
  logic [COUNT_WIDTH-1:0] cd_r     [TASKS];
  logic [COUNT_WIDTH-1:0] cd_nxt   [TASKS];
  logic [COUNT_WIDTH-1:0] rel_r    [TASKS];
  logic [COUNT_WIDTH-1:0] rel_nxt  [TASKS];
  logic [TASKS-1:0]       pend_r, pend_nxt;
  logic [TASKS-1:0]       susp_r, susp_nxt;
  logic [NOUT_W-1:0]      n_r, n_nxt;
  logic                   strobe_r, strobe_nxt;
  pts_out_t               res_r, res_nxt;

  logic [TASKS-1:0]       cand, rest;
  logic [TIDX_W-1:0]      sel;
  logic                   found;
  logic [MASK_W-1:0]      tick_mask;
  logic [COUNT_WIDTH-1:0] dec;

  assign q_pop      = (state_r == ST_IDLE) && !q_empty;
  assign out_strobe = strobe_r;
  assign out_res    = res_r;

  // lowest pending, unsuspended slot
  always_comb begin
    cand  = pend_r & ~susp_r;
    sel   = '0;
    found = 1'b0;
    for (int i = 0; i < TASKS; i++) begin
      if (cand[i] && !found) begin
        sel   = TIDX_W'(i);
        found = 1'b1;
      end
    end
    rest = cand;
    rest[sel] = 1'b0;
  end

  always_comb begin
    state_nxt  = state_r;
    pend_nxt   = pend_r;
    susp_nxt   = susp_r;
    n_nxt      = n_r;
    strobe_nxt = 1'b0;
    res_nxt    = '0;
    tick_mask  = '0;
    dec        = '0;
    for (int i = 0; i < TASKS; i++) begin
      cd_nxt[i]  = cd_r[i];
      rel_nxt[i] = rel_r[i];
    end

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          priority case (q_head.op)
            OP_TICK: begin
              for (int i = 0; i < TASKS; i++) begin
                dec = cd_r[i] - 1'b1;
                if (cd_r[i] != '0 && !susp_r[i]) begin
                  cd_nxt[i] = dec;
                  if (dec == '0) begin
                    cd_nxt[i]   = rel_r[i];
                    pend_nxt[i] = 1'b1;
                    if (i < MASK_W) tick_mask[i] = 1'b1;
                  end
                end
              end
              strobe_nxt         = 1'b1;
              res_nxt.last       = 1'b1;
              res_nxt.ready_mask = 8'(tick_mask);
            end
            OP_DISPATCH: begin
              state_nxt = ST_DISP;
              n_nxt     = '0;
            end
            OP_LOAD: begin
              cd_nxt[q_head.idx]   = q_head.value;
              rel_nxt[q_head.idx]  = q_head.value;
              pend_nxt[q_head.idx] = 1'b0;
            end
            OP_INTERVAL: begin
              rel_nxt[q_head.idx] = q_head.value;
            end
            OP_SUSPEND: begin
              susp_nxt[q_head.idx] = q_head.susp;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DISP: begin
        strobe_nxt = 1'b1;
        if (!found) begin
          // nothing pending: a single empty result
          res_nxt.last = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          pend_nxt[sel]          = 1'b0;
          res_nxt.valid_res      = 1'b1;
          res_nxt.task_index_out = 3'(sel);
          res_nxt.last           = (rest == '0) || (n_r == NOUT_W'(MAX_OUT - 1));
          n_nxt                  = n_r + 1'b1;
          if (res_nxt.last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pend_r   <= '0;
      susp_r   <= '0;
      n_r      <= '0;
      strobe_r <= 1'b0;
      for (int i = 0; i < TASKS; i++) begin
        cd_r[i]  <= '0;
        rel_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      pend_r   <= pend_nxt;
      susp_r   <= susp_nxt;
      n_r      <= n_nxt;
      strobe_r <= strobe_nxt;
      for (int i = 0; i < TASKS; i++) begin
        cd_r[i]  <= cd_nxt[i];
        rel_r[i] <= rel_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule
`default_nettype wire

FILE: sv/periodic_task_tick_scheduler.sv
// A tick result is registered from the queue head; slot writes take effect as the command leaves it.
// Dispatch: the first result follows the queue entry and the dispatch state; then one
// result per cycle from the single dispatch scan, up to 8 per dispatch; a dispatch
// leaves the queue as its scan starts and holds the unit until its last result.
// A 2-entry command queue decouples intake from execution; busy means it is full.
// Synchronous reset clears all slot countdowns, intervals and flags at once.
`default_nettype none
module periodic_task_tick_scheduler
  import pts_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire pts_in_t in_data,
  output logic         busy,
  output logic         out_strobe,
  output pts_out_t     out_res
);

  logic     q_push, q_pop, q_full, q_empty;
  pts_cmd_t q_cmd, q_head;

  pts_front u_front (
    .start   (start),
    .in_data (in_data),
    .q_full  (q_full),
    .busy    (busy),
    .q_push  (q_push),
    .q_cmd   (q_cmd)
  );

  pts_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  pts_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule
`default_nettype wire

FILE: sv/pts_checker.sv
// Port-level checks for the scheduler, bound to the top level.
`default_nettype none
module pts_checker
  import pts_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     out_strobe,
  input wire pts_out_t out_res
);

  a_quiet_after_reset: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_res.valid_res |-> out_res.last && out_res.task_index_out == 3'd0)
    else $error("empty result not final or carries an index");

  a_dispatch_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_res.valid_res |-> out_res.ready_mask == 8'd0)
    else $error("dispatched task carries a ready mask");

  a_burst_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_res.last |=> out_strobe && out_res.valid_res)
    else $error("dispatch burst broken");

  a_burst_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_res.last |=>
      out_res.task_index_out > $past(out_res.task_index_out))
    else $error("dispatch indices not ascending");

endmodule

bind periodic_task_tick_scheduler pts_checker u_pts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_strobe (out_strobe),
  .out_res    (out_res)
);
`default_nettype wire
